// ----- rtl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam int KEY_W  = 32;
    localparam int PRIO_W = 16;
    localparam int OCC_W  = 7;

    typedef struct packed {
        logic [1:0]               action;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic             hit;
        logic             overflow;
        logic             empty_res;
        logic [OCC_W-1:0] occupancy;
    } out_t;

    // One stored entry as it moves between neighbouring cells
    typedef struct packed {
        logic                     valid;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } slot_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic                     en;
        logic                     ins;
        logic                     pop;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/spq_cell.sv -----
// One compare-and-shift cell of the sorted queue chain.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire spq_pkg::cmd_t cmd,
    input  wire logic          left_take,
    input  wire spq_pkg::slot_t left_slot,
    input  wire spq_pkg::slot_t right_slot,
    output logic               take,
    output spq_pkg::slot_t     slot,
    output logic               match
);
    import spq_pkg::*;

    logic                     valid_reg, valid_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic                     match_reg, match_next;

    // Sorted order makes take monotone along the chain: the first taking
    // cell gets the new entry, those behind it take their left neighbour.
    assign take = cmd.ins & (~valid_reg | (prio_reg >= cmd.prio));

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        prio_next  = prio_reg;
        if (cmd.ins && take) begin
            if (left_take) begin
                valid_next = left_slot.valid;
                key_next   = left_slot.key;
                prio_next  = left_slot.prio;
            end else begin
                valid_next = 1'b1;
                key_next   = cmd.key;
                prio_next  = cmd.prio;
            end
        end else if (cmd.pop) begin
            valid_next = right_slot.valid;
            key_next   = right_slot.key;
            prio_next  = right_slot.prio;
        end
    end

    assign match_next = valid_reg & (key_reg == cmd.key) & (prio_reg == cmd.prio);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            key_reg   <= key_next;
            prio_reg  <= prio_next;
            match_reg <= match_next;
        end
    end

    assign slot  = '{valid: valid_reg, key: key_reg, prio: prio_reg};
    assign match = match_reg;

endmodule
`default_nettype wire

// ----- rtl/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: cell chain, count and result stage.
//
// Usage:
//   Requests arrive on s_valid/s_ready/s_data (action, key, prio); one
//   result per request leaves on m_valid/m_ready/m_data.
//   Insert puts the entry ahead of the first held entry whose priority is
//   not smaller; pop returns the head; query looks for an equal key and
//   priority. Every result carries the occupancy after the request.
//   Storage is a chain of CAPACITY cells. Each accepted request updates
//   all cells at once: inserts shift the tail one cell right, pops shift
//   the whole chain one cell left, and each cell registers its own
//   query match flag.
//   Timing: the accepting edge updates the cells and the pending stage;
//   the result stage loads from the pending stage once the output is free.
//   Throughput: one request per cycle while m_ready is high; the rate is
//   set by the cell update and the registered per-cell match flags.
//   Stalls: one request may sit in the pending stage while a result waits
//   in the output register; after that s_ready drops until m_ready.
//   Reset (aresetn low, synchronous) empties the queue and drops any
//   pending or waiting result.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire spq_pkg::in_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output spq_pkg::out_t  m_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             accept;
    logic             out_free;
    logic             full;
    logic             empty;
    cmd_t             cmd;

    slot_t            slots [CAPACITY];
    logic             takes [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    logic [CNT_W-1:0] count_reg, count_next;

    // pending stage: request already applied to the cells
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_query_reg;
    logic             pend_pop_hit_reg;
    logic [KEY_W-1:0] pend_key_reg;
    logic             pend_ovf_reg;
    logic [CNT_W-1:0] pend_count_reg;

    logic             out_valid_reg, out_valid_next;
    out_t             out_reg;

    assign out_free = ~out_valid_reg | m_ready;
    assign s_ready  = ~pend_valid_reg | out_free;
    assign accept   = s_valid & s_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb begin
        cmd.en   = accept;
        cmd.ins  = accept & (s_data.action == ACT_INSERT) & ~full;
        cmd.pop  = accept & (s_data.action == ACT_POP) & ~empty;
        cmd.key  = s_data.key;
        cmd.prio = s_data.prio;
    end

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic  left_take;
        slot_t left_slot;
        slot_t right_slot;

        if (i == 0) begin : g_head
            assign left_take = 1'b0;
            assign left_slot = '0;
        end else begin : g_mid
            assign left_take = takes[i-1];
            assign left_slot = slots[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_slot = '0;
        end else begin : g_body
            assign right_slot = slots[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_take  (left_take),
            .left_slot  (left_slot),
            .right_slot (right_slot),
            .take       (takes[i]),
            .slot       (slots[i]),
            .match      (match_vec[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // pending stage
    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (accept) begin
            pend_valid_next = 1'b1;
        end else if (out_free) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_query_reg   <= (s_data.action == ACT_QUERY);
            pend_pop_hit_reg <= cmd.pop;
            pend_key_reg     <= cmd.pop ? slots[0].key : '0;
            pend_ovf_reg     <= (s_data.action == ACT_INSERT) & full;
            pend_count_reg   <= count_next;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (pend_valid_reg && out_free) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_valid_reg && out_free) begin
            out_reg.out_key   <= pend_key_reg;
            out_reg.hit       <= pend_pop_hit_reg | (pend_query_reg & (|match_vec));
            out_reg.overflow  <= pend_ovf_reg;
            out_reg.empty_res <= (pend_count_reg == '0);
            out_reg.occupancy <= OCC_W'(pend_count_reg);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire
